// File: src/ppp_pkg.sv
// Shared constants and types for the perspective point projection block.
`timescale 1ns / 1ps

package ppp_pkg;

	localparam int ANGLE_BITS      = 16;
	localparam int COORD_FRAC_BITS = 8;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int AXIS_W   = 32;
	localparam int TERM_W   = 34;
	localparam int SUM_W    = 35;
	localparam int MAG_W    = 34;
	localparam int QUO_W    = 32;
	localparam int RATIO_W  = QUO_W + 1;
	localparam int RATIO_SHIFT = 16;
	localparam int FOCAL_W  = 32;
	localparam int PIX_W    = 16;
	localparam int DIM_W    = 14;
	localparam int CFG_W    = 32;

	localparam int DOT_STAGES = 4;
	localparam int DIV_STAGES = QUO_W + 1;
	localparam int PIX_STAGES = 5;
	localparam int PIPE_LAT   = DOT_STAGES + DIV_STAGES + PIX_STAGES;

	localparam int IN_W  = 3 * COORD_W;
	localparam int OUT_W = ((2 * PIX_W + 1 + 7) / 8) * 8;

	localparam logic [2:0] REG_PITCH  = 3'd0;
	localparam logic [2:0] REG_YAW    = 3'd1;
	localparam logic [2:0] REG_VIEW   = 3'd2;
	localparam logic [2:0] REG_CAM_X  = 3'd3;
	localparam logic [2:0] REG_CAM_Y  = 3'd4;
	localparam logic [2:0] REG_CAM_Z  = 3'd5;
	localparam logic [2:0] REG_WIDTH  = 3'd6;
	localparam logic [2:0] REG_HEIGHT = 3'd7;

	typedef struct packed {
		logic signed [AXIS_W-1:0] fwd_x;
		logic signed [AXIS_W-1:0] fwd_y;
		logic signed [AXIS_W-1:0] fwd_z;
		logic signed [AXIS_W-1:0] right_x;
		logic signed [AXIS_W-1:0] right_y;
		logic signed [AXIS_W-1:0] up_x;
		logic signed [AXIS_W-1:0] up_y;
		logic signed [AXIS_W-1:0] up_z;
		logic [FOCAL_W-1:0]       focal;
	} cam_t;

endpackage

// File: src/ppp_setup.sv
// Camera setup sequencer: sines, cosines, view basis and focal length on one shared multiplier.
`timescale 1ns / 1ps

module ppp_setup (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic [15:0]                pitch,
	input  logic [15:0]                yaw,
	input  logic [14:0]                view_angle,
	input  logic [ppp_pkg::DIM_W-1:0]  width,
	output logic                       done,
	output ppp_pkg::cam_t              cam
);
	import ppp_pkg::*;

	localparam logic [2:0] ST_SINE  = 3'd0;
	localparam logic [2:0] ST_BASIS = 3'd1;
	localparam logic [2:0] ST_FOCAL = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [2:0] SS_PREP  = 3'd0;
	localparam logic [2:0] SS_SQ    = 3'd1;
	localparam logic [2:0] SS_C     = 3'd2;
	localparam logic [2:0] SS_B     = 3'd3;
	localparam logic [2:0] SS_A     = 3'd4;
	localparam logic [2:0] SS_STORE = 3'd5;

	localparam logic [2:0] BS_FX = 3'd0;
	localparam logic [2:0] BS_FY = 3'd1;
	localparam logic [2:0] BS_UX = 3'd2;
	localparam logic [2:0] BS_UY = 3'd3;

	localparam logic [2:0] FS_MUL = 3'd0;
	localparam logic [2:0] FS_CHK = 3'd1;

	localparam logic [2:0] SC_SP = 3'd0;
	localparam logic [2:0] SC_CP = 3'd1;
	localparam logic [2:0] SC_SY = 3'd2;
	localparam logic [2:0] SC_CY = 3'd3;
	localparam logic [2:0] SC_SH = 3'd4;
	localparam logic [2:0] SC_CH = 3'd5;

	localparam logic [1:0] ANG_PITCH = 2'd0;
	localparam logic [1:0] ANG_YAW   = 2'd1;
	localparam logic [1:0] ANG_HALF  = 2'd2;

	localparam int QW = ANGLE_BITS - 2;
	localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {QW{1'b0}}};
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] SIN_A = 31'd1686629713;
	localparam logic [30:0] SIN_B = 31'd688904866;
	localparam logic [30:0] SIN_C = 31'd76016977;
	localparam logic [QUO_W:0] FOCAL_LIM = {1'b1, {QUO_W{1'b0}}} >> 1;

	function automatic logic [ANGLE_BITS-1:0] to_phase(input logic [15:0] a);
		logic [ANGLE_BITS+15:0] t;
		t = {a, {ANGLE_BITS{1'b0}}};
		return t[ANGLE_BITS+15:16];
	endfunction

	function automatic logic [ANGLE_BITS-1:0] half_phase(input logic [14:0] v);
		logic [ANGLE_BITS+14:0] t;
		t = {v, {ANGLE_BITS{1'b0}}};
		return ANGLE_BITS'(t >> 17);
	endfunction

	logic [2:0]  state_q, sub_q, idx_q;
	logic [30:0] x_q, x2_q;
	logic [31:0] t_q;
	logic [1:0]  quad_q;
	logic signed [AXIS_W-1:0] sc_q [0:5];
	logic [51:0] numer_q;
	logic [31:0] den_q, rem_q, quo_q;
	logic        sat_q;
	logic [4:0]  cnt_q;
	cam_t        cam_q;

	logic [ANGLE_BITS-1:0] base, ph;
	logic [1:0]            quad;
	logic [29:0]           frac;
	logic [30:0]           x_new;
	logic signed [32:0]    mul_a, mul_b;
	logic signed [65:0]    prod;
	logic [30:0]           mag31;
	logic signed [31:0]    sval, shs, chc;
	logic [31:0]           nlow;
	logic [32:0]           rr, rdiff;
	logic                  ge;
	logic [QUO_W:0]        qfull;

	always_comb begin
		case (idx_q[2:1])
			ANG_PITCH: base = to_phase(pitch);
			ANG_YAW:   base = to_phase(yaw);
			ANG_HALF:  base = half_phase(view_angle);
			default:   base = '0;
		endcase
		ph    = base + (idx_q[0] ? QUARTER : '0);
		quad  = ph[ANGLE_BITS-1:ANGLE_BITS-2];
		frac  = {ph[QW-1:0], {(30-QW){1'b0}}};
		x_new = quad[0] ? ONE_Q30 - {1'b0, frac} : {1'b0, frac};
		mag31 = (t_q > {1'b0, ONE_Q30}) ? ONE_Q30 : t_q[30:0];
		sval  = signed'({1'b0, mag31});
		shs   = (sc_q[SC_SH] < 32'sd1) ? 32'sd1 : sc_q[SC_SH];
		chc   = sc_q[SC_CH][31] ? 32'sd0 : sc_q[SC_CH];
		nlow  = numer_q[31:0];
		rr    = {rem_q, nlow[cnt_q]};
		ge    = rr >= {1'b0, den_q};
		rdiff = rr - {1'b0, den_q};
		qfull = {1'b0, quo_q};
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SINE: begin
				case (sub_q)
					SS_SQ: begin
						mul_a = 33'(x_q);
						mul_b = 33'(x_q);
					end
					SS_C: begin
						mul_a = 33'(SIN_C);
						mul_b = 33'(x2_q);
					end
					SS_B: begin
						mul_a = 33'(SIN_B) - 33'(t_q);
						mul_b = 33'(x2_q);
					end
					SS_A: begin
						mul_a = 33'(SIN_A) - 33'(t_q);
						mul_b = 33'(x_q);
					end
					default: ;
				endcase
			end
			ST_BASIS: begin
				case (sub_q)
					BS_FX: begin
						mul_a = 33'(sc_q[SC_CP]);
						mul_b = 33'(sc_q[SC_CY]);
					end
					BS_FY: begin
						mul_a = 33'(sc_q[SC_CP]);
						mul_b = 33'(sc_q[SC_SY]);
					end
					BS_UX: begin
						mul_a = 33'(sc_q[SC_SP]);
						mul_b = 33'(sc_q[SC_CY]);
					end
					BS_UY: begin
						mul_a = 33'(sc_q[SC_SP]);
						mul_b = 33'(sc_q[SC_SY]);
					end
					default: ;
				endcase
			end
			ST_FOCAL: begin
				mul_a = 33'(width);
				mul_b = 33'(chc);
			end
			ST_DIV, ST_FIN, ST_DONE: ;
			default: ;
		endcase
		prod = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SINE;
			sub_q   <= SS_PREP;
			idx_q   <= SC_SP;
			cnt_q   <= '0;
		end else if (restart) begin
			state_q <= ST_SINE;
			sub_q   <= SS_PREP;
			idx_q   <= SC_SP;
		end else begin
			unique case (state_q)
				ST_SINE: begin
					if (sub_q == SS_STORE) begin
						if (idx_q == SC_CH) begin
							state_q <= ST_BASIS;
							sub_q   <= BS_FX;
						end else begin
							sub_q <= SS_PREP;
							idx_q <= idx_q + 3'd1;
						end
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_BASIS: begin
					if (sub_q == BS_UY) begin
						state_q <= ST_FOCAL;
						sub_q   <= FS_MUL;
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_FOCAL: begin
					if (sub_q == FS_CHK) begin
						state_q <= ST_DIV;
						cnt_q   <= 5'd31;
					end else begin
						sub_q <= FS_CHK;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0)
						state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_DONE;
				ST_DONE: ;
				default: state_q <= ST_SINE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SINE: begin
				case (sub_q)
					SS_PREP: begin
						x_q    <= x_new;
						quad_q <= quad;
					end
					SS_SQ:    x2_q <= prod[60:30];
					SS_C, SS_B, SS_A: t_q <= prod[61:30];
					SS_STORE: sc_q[idx_q] <= quad_q[1] ? -sval : sval;
					default: ;
				endcase
			end
			ST_BASIS: begin
				case (sub_q)
					BS_FX: cam_q.fwd_x <= prod[61:30];
					BS_FY: cam_q.fwd_y <= prod[61:30];
					BS_UX: cam_q.up_x  <= -prod[61:30];
					BS_UY: begin
						cam_q.up_y    <= -prod[61:30];
						cam_q.fwd_z   <= sc_q[SC_SP];
						cam_q.right_x <= -sc_q[SC_SY];
						cam_q.right_y <= sc_q[SC_CY];
						cam_q.up_z    <= sc_q[SC_CP];
					end
					default: ;
				endcase
			end
			ST_FOCAL: begin
				if (sub_q == FS_MUL) begin
					numer_q <= {prod[43:0], 8'd0};
					den_q   <= {shs[30:0], 1'b0};
				end else begin
					sat_q <= {12'd0, numer_q[51:32]} >= den_q;
					rem_q <= {12'd0, numer_q[51:32]};
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= ge ? rdiff[31:0] : rr[31:0];
				quo_q <= {quo_q[30:0], ge};
			end
			ST_FIN: cam_q.focal <= (sat_q || qfull > FOCAL_LIM) ? FOCAL_LIM[QUO_W-1:0] : quo_q;
			ST_DONE: ;
			default: ;
		endcase
	end

	assign done = (state_q == ST_DONE) && !restart;
	assign cam  = cam_q;

endmodule

// File: src/ppp_dot.sv
// Front pipeline: offset from camera, dot products with the view basis, depth clamp.
`timescale 1ns / 1ps

module ppp_dot (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [ppp_pkg::COORD_W-1:0] world_x,
	input  logic signed [ppp_pkg::COORD_W-1:0] world_y,
	input  logic signed [ppp_pkg::COORD_W-1:0] world_z,
	input  logic signed [ppp_pkg::COORD_W-1:0] cam_x,
	input  logic signed [ppp_pkg::COORD_W-1:0] cam_y,
	input  logic signed [ppp_pkg::COORD_W-1:0] cam_z,
	input  ppp_pkg::cam_t                      cam,
	output logic [ppp_pkg::MAG_W-1:0]          mag_x,
	output logic [ppp_pkg::MAG_W-1:0]          mag_y,
	output logic [ppp_pkg::MAG_W-1:0]          den,
	output logic                               neg_x,
	output logic                               neg_y
);
	import ppp_pkg::*;

	localparam logic signed [SUM_W-1:0] ONE_W = SUM_W'(1) << COORD_FRAC_BITS;

	function automatic logic signed [TERM_W-1:0] mulq(input logic signed [DIFF_W-1:0] d,
		input logic signed [AXIS_W-1:0] a);
		logic signed [DIFF_W+AXIS_W-1:0] p;
		p = d * a;
		return p[TERM_W+29:30];
	endfunction

	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [TERM_W-1:0] rx_s2, ry_s2, ux_s2, uy_s2, uz_s2, fx_s2, fy_s2, fz_s2;
	logic signed [SUM_W-1:0]  cx_s3, cy_s3, cz_s3;
	logic [MAG_W-1:0]         mx_s4, my_s4, den_s4;
	logic                     nx_s4, ny_s4;
	logic signed [SUM_W-1:0]  ax, ay;

	always_comb begin
		ax = cx_s3[SUM_W-1] ? -cx_s3 : cx_s3;
		ay = cy_s3[SUM_W-1] ? -cy_s3 : cy_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DIFF_W'(world_x) - DIFF_W'(cam_x);
			dy_s1 <= DIFF_W'(world_y) - DIFF_W'(cam_y);
			dz_s1 <= DIFF_W'(world_z) - DIFF_W'(cam_z);

			rx_s2 <= mulq(dx_s1, cam.right_x);
			ry_s2 <= mulq(dy_s1, cam.right_y);
			ux_s2 <= mulq(dx_s1, cam.up_x);
			uy_s2 <= mulq(dy_s1, cam.up_y);
			uz_s2 <= mulq(dz_s1, cam.up_z);
			fx_s2 <= mulq(dx_s1, cam.fwd_x);
			fy_s2 <= mulq(dy_s1, cam.fwd_y);
			fz_s2 <= mulq(dz_s1, cam.fwd_z);

			cx_s3 <= SUM_W'(rx_s2) + SUM_W'(ry_s2);
			cy_s3 <= SUM_W'(ux_s2) + SUM_W'(uy_s2) + SUM_W'(uz_s2);
			cz_s3 <= SUM_W'(fx_s2) + SUM_W'(fy_s2) + SUM_W'(fz_s2);

			mx_s4  <= ax[MAG_W-1:0];
			my_s4  <= ay[MAG_W-1:0];
			nx_s4  <= cx_s3[SUM_W-1];
			ny_s4  <= cy_s3[SUM_W-1];
			den_s4 <= (cz_s3 < ONE_W) ? ONE_W[MAG_W-1:0] : cz_s3[MAG_W-1:0];
		end
	end

	assign mag_x = mx_s4;
	assign mag_y = my_s4;
	assign neg_x = nx_s4;
	assign neg_y = ny_s4;
	assign den   = den_s4;

endmodule

// File: src/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module ppp_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [ppp_pkg::MAG_W-1:0]   mag,
	input  logic [ppp_pkg::MAG_W-1:0]   den,
	input  logic                        neg,
	output logic [ppp_pkg::QUO_W-1:0]   quo,
	output logic                        sat,
	output logic                        neg_o
);
	import ppp_pkg::*;

	logic [MAG_W-1:0] rem_s [0:QUO_W];
	logic [QUO_W-1:0] nlo_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [MAG_W-1:0] den_s [0:QUO_W];
	logic [QUO_W:0]   sat_s;
	logic [QUO_W:0]   neg_s;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= MAG_W'(mag >> RATIO_SHIFT);
			nlo_s[0] <= {mag[RATIO_SHIFT-1:0], {(QUO_W-RATIO_SHIFT){1'b0}}};
			quo_s[0] <= '0;
			den_s[0] <= den;
			sat_s[0] <= MAG_W'(mag >> RATIO_SHIFT) >= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
		logic [MAG_W:0] rr, diff;
		logic           ge;
		assign rr   = {rem_s[k-1], nlo_s[k-1][QUO_W-1]};
		assign diff = rr - {1'b0, den_s[k-1]};
		assign ge   = rr >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[MAG_W-1:0] : rr[MAG_W-1:0];
				nlo_s[k] <= {nlo_s[k-1][QUO_W-2:0], 1'b0};
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge};
				den_s[k] <= den_s[k-1];
				sat_s[k] <= sat_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	assign quo   = quo_s[QUO_W];
	assign sat   = sat_s[QUO_W];
	assign neg_o = neg_s[QUO_W];

endmodule

// File: src/ppp_pixel.sv
// Back pipeline: ratio saturation, focal scaling, screen offset, 16-bit clamp and bounds test.
`timescale 1ns / 1ps

module ppp_pixel (
	input  logic                               clk,
	input  logic                               en,
	input  logic [ppp_pkg::QUO_W-1:0]          quo_x,
	input  logic                               sat_x,
	input  logic                               neg_x,
	input  logic [ppp_pkg::QUO_W-1:0]          quo_y,
	input  logic                               sat_y,
	input  logic                               neg_y,
	input  logic [ppp_pkg::FOCAL_W-1:0]        focal,
	input  logic [ppp_pkg::DIM_W-1:0]          width,
	input  logic [ppp_pkg::DIM_W-1:0]          height,
	output logic signed [ppp_pkg::PIX_W-1:0]   pixel_x,
	output logic signed [ppp_pkg::PIX_W-1:0]   pixel_y,
	output logic                               on_screen
);
	import ppp_pkg::*;

	localparam logic [QUO_W:0] RATIO_LIM = {1'b1, {QUO_W{1'b0}}} >> 1;
	localparam logic signed [39:0] PIX_MAX = 40'sd32767;
	localparam logic signed [39:0] PIX_MIN = -40'sd32768;

	function automatic logic signed [RATIO_W-1:0] ratio(input logic [QUO_W-1:0] q,
		input logic s, input logic n);
		logic [QUO_W:0] m;
		m = (s || {1'b0, q} > RATIO_LIM) ? RATIO_LIM : {1'b0, q};
		return n ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic signed [PIX_W-1:0] sat16(input logic signed [39:0] v);
		if (v > PIX_MAX)
			return PIX_W'(PIX_MAX);
		if (v < PIX_MIN)
			return PIX_W'(PIX_MIN);
		return v[PIX_W-1:0];
	endfunction

	logic signed [RATIO_W-1:0] rx_s1, ry_s1;
	logic signed [63:0]        px_s2, py_s2;
	logic signed [63:0]        sx_s3, sy_s3;
	logic signed [PIX_W-1:0]   px_s4, py_s4;
	logic signed [PIX_W-1:0]   px_s5, py_s5;
	logic                      on_s5;
	logic signed [65:0]        mx, my;
	logic signed [63:0]        wb, hb;
	logic signed [PIX_W:0]     ws, hs;

	always_comb begin
		mx = rx_s1 * signed'({1'b0, focal});
		my = ry_s1 * signed'({1'b0, focal});
		wb = 64'(signed'({1'b0, width})) <<< 23;
		hb = 64'(signed'({1'b0, height})) <<< 23;
		ws = signed'({{(PIX_W+1-DIM_W){1'b0}}, width});
		hs = signed'({{(PIX_W+1-DIM_W){1'b0}}, height});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= ratio(quo_x, sat_x, neg_x);
			ry_s1 <= ratio(quo_y, sat_y, neg_y);
			px_s2 <= mx[63:0];
			py_s2 <= my[63:0];
			sx_s3 <= wb + px_s2;
			sy_s3 <= hb - py_s2;
			px_s4 <= sat16(sx_s3[63:24]);
			py_s4 <= sat16(sy_s3[63:24]);
			px_s5 <= px_s4;
			py_s5 <= py_s4;
			on_s5 <= (px_s4 > 16'sd0) && (py_s4 > 16'sd0) &&
				((PIX_W+1)'(px_s4) <= ws) && ((PIX_W+1)'(py_s4) <= hs);
		end
	end

	assign pixel_x   = px_s5;
	assign pixel_y   = py_s5;
	assign on_screen = on_s5;

endmodule

// File: src/perspective_point_projection.sv
// Top level of the perspective point projection block.
`timescale 1ns / 1ps

// Projects one world point per clock to a screen pixel while s_tready is high. After reset
// and after every register write the setup sequencer rebuilds the sines, the view basis and
// the focal length on its shared multiplier and bit-serial divider; s_tready stays low until
// it is done. A point is then taken every cycle unless the output buffer is full, and goes
// through the front pipeline, the 33-stage depth divider and the back pipeline. A two-entry
// output buffer lets requests keep flowing while a result waits to be taken.
module perspective_point_projection (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [ppp_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ppp_pkg::IN_W-1:0]      s_tdata,  // world_x, world_y, world_z
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ppp_pkg::OUT_W-1:0]     m_tdata   // pixel_x, pixel_y, on_screen, zero pad
);
	import ppp_pkg::*;

	logic [15:0]               pitch_q, yaw_q;
	logic [14:0]               view_q;
	logic signed [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic [DIM_W-1:0]          width_q, height_q;

	logic                      setup_done, en, push, pop;
	cam_t                      cam;
	logic [PIPE_LAT-1:0]       vld_s;
	logic [1:0]                cnt_q;
	logic [OUT_W-1:0]          obuf0_q, obuf1_q, res;

	logic [MAG_W-1:0]          mag_x, mag_y, den;
	logic                      neg_x, neg_y, dneg_x, dneg_y, sat_x, sat_y;
	logic [QUO_W-1:0]          quo_x, quo_y;
	logic signed [PIX_W-1:0]   pixel_x, pixel_y;
	logic                      on_screen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q  <= '0;
			yaw_q    <= '0;
			view_q   <= 15'd16384;
			cam_x_q  <= '0;
			cam_y_q  <= '0;
			cam_z_q  <= '0;
			width_q  <= 14'd1920;
			height_q <= 14'd1080;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PITCH:  pitch_q  <= cfg_wdata[15:0];
				REG_YAW:    yaw_q    <= cfg_wdata[15:0];
				REG_VIEW:   view_q   <= cfg_wdata[14:0];
				REG_CAM_X:  cam_x_q  <= cfg_wdata;
				REG_CAM_Y:  cam_y_q  <= cfg_wdata;
				REG_CAM_Z:  cam_z_q  <= cfg_wdata;
				REG_WIDTH:  width_q  <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	ppp_setup u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.pitch      (pitch_q),
		.yaw        (yaw_q),
		.view_angle (view_q),
		.width      (width_q),
		.done       (setup_done),
		.cam        (cam)
	);

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en && setup_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[PIPE_LAT-2:0], s_tvalid && s_tready};
	end

	ppp_dot u_dot (
		.clk     (clk),
		.en      (en),
		.world_x (s_tdata[COORD_W-1:0]),
		.world_y (s_tdata[2*COORD_W-1:COORD_W]),
		.world_z (s_tdata[3*COORD_W-1:2*COORD_W]),
		.cam_x   (cam_x_q),
		.cam_y   (cam_y_q),
		.cam_z   (cam_z_q),
		.cam     (cam),
		.mag_x   (mag_x),
		.mag_y   (mag_y),
		.den     (den),
		.neg_x   (neg_x),
		.neg_y   (neg_y)
	);

	ppp_div u_div_x (
		.clk   (clk),
		.en    (en),
		.mag   (mag_x),
		.den   (den),
		.neg   (neg_x),
		.quo   (quo_x),
		.sat   (sat_x),
		.neg_o (dneg_x)
	);

	ppp_div u_div_y (
		.clk   (clk),
		.en    (en),
		.mag   (mag_y),
		.den   (den),
		.neg   (neg_y),
		.quo   (quo_y),
		.sat   (sat_y),
		.neg_o (dneg_y)
	);

	ppp_pixel u_pixel (
		.clk       (clk),
		.en        (en),
		.quo_x     (quo_x),
		.sat_x     (sat_x),
		.neg_x     (dneg_x),
		.quo_y     (quo_y),
		.sat_y     (sat_y),
		.neg_y     (dneg_y),
		.focal     (cam.focal),
		.width     (width_q),
		.height    (height_q),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.on_screen (on_screen)
	);

	assign res  = {{(OUT_W-2*PIX_W-1){1'b0}}, on_screen, pixel_y, pixel_x};
	assign push = en && vld_s[PIPE_LAT-1];
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (push && !pop)
			cnt_q <= cnt_q + 2'd1;
		else if (pop && !push)
			cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0)
					obuf0_q <= res;
				else
					obuf1_q <= res;
			end
			2'b01: obuf0_q <= obuf1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					obuf0_q <= res;
				end else begin
					obuf0_q <= obuf1_q;
					obuf1_q <= res;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = obuf0_q;

endmodule

// File: tb/perspective_point_projection_test.sv
// Testbench for the perspective point projection block: directed and random points against a predictor.
`timescale 1ns / 1ps

module perspective_point_projection_test;
	import ppp_pkg::*;

	typedef struct {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic               on;
	} pixel_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we = 1'b0;
	logic [2:0]          cfg_index = REG_PITCH;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	logic [15:0] cam_pitch = 16'd0;
	logic [15:0] cam_yaw = 16'd0;
	logic [14:0] fov = 15'd16384;
	logic [31:0] cam_x = '0, cam_y = '0, cam_z = '0;
	logic [13:0] scr_w = 14'd1920, scr_h = 14'd1080;

	pixel_t pending_pixels[$];
	int     errors = 0;
	int     points_sent = 0;
	int     pixels_seen = 0;
	int     cfg_phases = 0;
	bit     idle_en = 1'b1;
	int     hold_cycles = 0;

	perspective_point_projection uut (.*);

	always #10 clk = ~clk;

	function automatic longint sine_q30(longint unsigned phase);
		longint unsigned p, x, x2, t;
		logic [1:0] quad;
		p = phase & 64'hFFFF;
		quad = p[15:14];
		x = (p & 64'h3FFF) << 16;
		if (quad[0])
			x = (64'd1 << 30) - x;
		x2 = (x * x) >> 30;
		t = (64'd76016977 * x2) >> 30;
		t = 64'd688904866 - t;
		t = (t * x2) >> 30;
		t = 64'd1686629713 - t;
		t = (t * x) >> 30;
		if (t > (64'd1 << 30))
			t = 64'd1 << 30;
		return quad[1] ? -longint'(t) : longint'(t);
	endfunction

	function automatic longint sat_ratio(longint num, longint den);
		longint r;
		r = (num * 65536) / den;
		if (r > (64'sd1 <<< 31)) r = 64'sd1 <<< 31;
		if (r < -(64'sd1 <<< 31)) r = -(64'sd1 <<< 31);
		return r;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic pixel_t project_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
		longint sp, cp, sy, cy, sh, ch, dx, dy, dz, rx, ry, cxv, cyv, czv, focal, w, h, pxl, pyl;
		longint fx, fy, fz, rgx, rgy, ux, uy, uz;
		pixel_t res;
		sp = sine_q30(cam_pitch);
		cp = sine_q30(cam_pitch + 16'd16384);
		sy = sine_q30(cam_yaw);
		cy = sine_q30(cam_yaw + 16'd16384);
		fx = (cp * cy) >>> 30;
		fy = (cp * sy) >>> 30;
		fz = sp;
		rgx = -sy;
		rgy = cy;
		ux = -((sp * cy) >>> 30);
		uy = -((sp * sy) >>> 30);
		uz = cp;
		dx = longint'($signed(wx)) - longint'($signed(cam_x));
		dy = longint'($signed(wy)) - longint'($signed(cam_y));
		dz = longint'($signed(wz)) - longint'($signed(cam_z));
		cxv = ((dx * rgx) >>> 30) + ((dy * rgy) >>> 30);
		cyv = ((dx * ux) >>> 30) + ((dy * uy) >>> 30) + ((dz * uz) >>> 30);
		czv = ((dx * fx) >>> 30) + ((dy * fy) >>> 30) + ((dz * fz) >>> 30);
		if (czv < 256)
			czv = 256;
		sh = sine_q30(fov >> 1);
		ch = sine_q30((fov >> 1) + 16384);
		if (sh < 1) sh = 1;
		if (ch < 0) ch = 0;
		w = scr_w;
		h = scr_h;
		focal = (w * ch * 256) / (2 * sh);
		if (focal > (64'sd1 <<< 31)) focal = 64'sd1 <<< 31;
		rx = sat_ratio(cxv, czv);
		ry = sat_ratio(cyv, czv);
		pxl = sat16((w * (64'sd1 <<< 23) + rx * focal) >>> 24);
		pyl = sat16((h * (64'sd1 <<< 23) - ry * focal) >>> 24);
		res.px = pxl[15:0];
		res.py = pyl[15:0];
		res.on = pxl >= 1 && pyl >= 1 && pxl <= w && pyl <= h;
		return res;
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pending_pixels.push_back(project_point(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]));
			points_sent++;
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (m_tvalid && m_tready) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel %h", m_tdata);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[15:0] !== want.px) begin
					$error("pixel_x expected %0d got %0d", want.px, $signed(m_tdata[15:0]));
					errors++;
				end
				if (m_tdata[31:16] !== want.py) begin
					$error("pixel_y expected %0d got %0d", want.py, $signed(m_tdata[31:16]));
					errors++;
				end
				if (m_tdata[32] !== want.on) begin
					$error("on_screen expected %0d got %0d", want.on, m_tdata[32]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= !(idle_en && $urandom_range(0, 99) < 21);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PITCH:  cam_pitch = val[15:0];
			REG_YAW:    cam_yaw = val[15:0];
			REG_VIEW:   fov = val[14:0];
			REG_CAM_X:  cam_x = val;
			REG_CAM_Y:  cam_y = val;
			REG_CAM_Z:  cam_z = val;
			REG_WIDTH:  scr_w = val[13:0];
			REG_HEIGHT: scr_h = val[13:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_camera(logic [15:0] p, logic [15:0] y, logic [14:0] v,
			logic [31:0] x, logic [31:0] yy, logic [31:0] z, logic [13:0] w, logic [13:0] h);
		write_reg(REG_PITCH, {16'd0, p});
		write_reg(REG_YAW, {16'd0, y});
		write_reg(REG_VIEW, {17'd0, v});
		write_reg(REG_CAM_X, x);
		write_reg(REG_CAM_Y, yy);
		write_reg(REG_CAM_Z, z);
		write_reg(REG_WIDTH, {18'd0, w});
		write_reg(REG_HEIGHT, {18'd0, h});
		cfg_phases++;
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if (idle_en) begin
			while ($urandom_range(0, 99) < 21) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	// drop the request line, then wait until every pending pixel has come back
	task automatic drain;
		int n;
		s_tvalid <= 1'b0;
		n = 0;
		while (pending_pixels.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (PIPE_LAT + 20) @(posedge clk);
	endtask

	function automatic logic [31:0] near_value(logic [31:0] base, int span);
		return base + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic send_viewed_point;
		longint sp, cp, sy, cy, reach;
		logic [31:0] x, y, z;
		sp = sine_q30(cam_pitch);
		cp = sine_q30(cam_pitch + 16'd16384);
		sy = sine_q30(cam_yaw);
		cy = sine_q30(cam_yaw + 16'd16384);
		reach = $urandom_range(1, 1 << 20);
		x = cam_x + 32'(((((cp * cy) >>> 30) * reach) >>> 30));
		y = cam_y + 32'(((((cp * sy) >>> 30) * reach) >>> 30));
		z = cam_z + 32'((sp * reach) >>> 30);
		send_point(near_value(x, int'(reach / 2 + 1)), near_value(y, int'(reach / 2 + 1)),
			near_value(z, int'(reach / 2 + 1)));
	endtask

	task automatic test_reset_values;
		send_point(32'd25600, 32'd0, 32'd0);
		send_point(32'd25600, 32'd2560, -32'sd2560);
		send_point(32'd0, 32'd0, 32'd0);
		drain();
	endtask

	task automatic test_field_extremes;
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_point(32'h80000000, 32'h80000000, 32'h80000000);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h0);
		send_point(-32'sd25600, 32'd100, 32'd100);
		send_point(32'd1, 32'h7FFFFFFF, 32'h80000000);
		send_point(32'hFFFFFFFF, 32'd0, 32'd0);
		drain();
		load_camera(16'sd16384, 16'd65535, 15'd1, 32'h80000000, 32'h7FFFFFFF, 32'h0,
			14'd8192, 14'd8192);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send_point(32'd0, 32'd0, 32'd0);
		send_point(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
		drain();
		load_camera(-16'sd16384, 16'd0, 15'd32767, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
			14'd1, 14'd1);
		send_point(32'h7FFFFFFF, 32'h80000000, 32'h80000000);
		send_point(32'd12345, 32'd67890, 32'h80000000);
		send_point(32'h0, 32'h0, 32'h0);
		drain();
		load_camera(16'h8000, 16'd49152, 15'd16, 32'd0, 32'd0, 32'd0, 14'd640, 14'd480);
		send_point(32'h7FFFFFFF, 32'd5000, 32'd5000);
		send_point(-32'sd40000, 32'd1000, -32'sd1000);
		send_point(32'd0, 32'd0, -32'sd90000);
		drain();
	endtask

	task automatic test_random_cameras;
		for (int phase = 0; phase < 8; phase++) begin
			load_camera(16'($urandom_range(0, 32768) - 16384), 16'($urandom),
				15'($urandom_range(1, 32767)), $urandom, $urandom, $urandom,
				14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
			idle_en = (phase != 3);
			for (int i = 0; i < 35; i++) begin
				if ($urandom_range(0, 99) < 75)
					send_viewed_point();
				else
					send_point($urandom, $urandom, $urandom);
			end
			drain();
		end
		idle_en = 1'b1;
	endtask

	task automatic test_output_stall;
		load_camera(16'd2000, 16'd30000, 15'd12000, 32'd4096, -32'sd8192, 32'd512,
			14'd1280, 14'd720);
		hold_cycles = 300;
		for (int i = 0; i < 120; i++)
			send_viewed_point();
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_field_extremes();
		test_random_cameras();
		test_output_stall();
		$display("Covered %0d points over %0d camera settings, %0d pixels checked.",
			points_sent, cfg_phases, pixels_seen);
		$display("Settings included extreme pitch, yaw, view angle, position and screen size.");
		if (errors == 0 && pending_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
